@@ design/lrts_pkg.sv @@
// Shared opcodes and control types for the longest-remaining-time scheduler.
package lrts_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic clear;
    logic cmp_vld;
  } pick_ctl_t;

endpackage

@@ design/longest_remaining_time_scheduler_unit.sv @@
// Top level of the preemptive longest-remaining-time-first scheduler.
//
//   channel | signals                                   | direction
//   request | in_valid_i, in_stall_o, opcode_i, ...     | in
//   result  | out_valid_o, out_stall_i, idle_o, ...     | out
//
// A load request is taken while the unit is idle and gives no result.
// A tick request stalls the input while it runs one table read per job slot
// through the single memory read port, waits for the registered read, then
// passes the write-back and result stages; its result is registered as it
// leaves the result stage.
// Reset clears the clock, the slot activity bits and the active-job count;
// no clearing pass runs. A held result keeps the next tick in the result
// stage, which holds the input stalled.
module longest_remaining_time_scheduler_unit import lrts_pkg::*; #(
  parameter int JOB_COUNT  = 16,
  parameter int TIME_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [3:0]  job_index_i,
  input  logic [15:0] arrival_time_i,
  input  logic [15:0] burst_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        idle_o,
  output logic [3:0]  ran_job_o,
  output logic        finished_o,
  output logic [15:0] completion_time_o,
  output logic [15:0] turnaround_time_o,
  output logic [15:0] waiting_time_o,
  output logic        all_done_o
);

  localparam int AW = $clog2(JOB_COUNT);
  localparam int CW = $clog2(JOB_COUNT + 1);
  localparam int TW = TIME_WIDTH;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_RES
  } state_e;

  state_e         state_q;
  logic [TW-1:0]  tick_q;
  logic [JOB_COUNT-1:0] act_q;
  logic [CW-1:0]  cnt_q;
  logic [CW-1:0]  scan_q;
  logic           cmp_vld_q;
  logic [AW-1:0]  cmp_idx_q;
  logic           done_q;
  logic [TW-1:0]  comp_q, turn_q;

  logic           out_valid_q, idle_q, fin_q, all_done_q;
  logic [3:0]     ran_q;
  logic [15:0]    comp_out_q, turn_out_q, wait_out_q;

  logic           accept, is_load, in_range;
  logic [AW-1:0]  load_addr;
  logic [TW-1:0]  load_arr, load_brs;
  logic [TW-1:0]  end_tick, new_rem, wait_val;
  logic [AW-1:0]  rd_addr;

  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [TW-1:0]  wr_arr, wr_brs, wr_rem;
  logic [TW-1:0]  rd_arr, rd_brs, rd_rem;

  pick_ctl_t      pick_ctl;
  logic           found;
  logic [AW-1:0]  best_idx;
  logic [TW-1:0]  best_arr, best_brs, best_rem;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_load    = (opcode_i == OP_LOAD);
  assign in_range   = (32'(job_index_i) < JOB_COUNT);
  assign load_addr  = AW'(job_index_i);
  assign load_arr   = TW'(arrival_time_i);
  assign load_brs   = TW'(burst_length_i);

  assign end_tick = (tick_q == {TW{1'b1}}) ? tick_q : tick_q + TW'(1);
  assign new_rem  = best_rem - TW'(1);
  assign wait_val = (turn_q >= best_brs) ? turn_q - best_brs : '0;
  assign rd_addr  = scan_q[AW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = load_addr;
    wr_arr  = load_arr;
    wr_brs  = load_brs;
    wr_rem  = load_brs;
    if (state_q == ST_IDLE) begin
      wr_en = accept && is_load && in_range;
    end else if (state_q == ST_UPD) begin
      wr_en   = found;
      wr_addr = best_idx;
      wr_arr  = best_arr;
      wr_brs  = best_brs;
      wr_rem  = new_rem;
    end
  end

  assign pick_ctl.clear   = accept && !is_load;
  assign pick_ctl.cmp_vld = cmp_vld_q;

  lrts_job_mem #(
    .AW (AW),
    .TW (TW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_arr_i  (wr_arr),
    .wr_brs_i  (wr_brs),
    .wr_rem_i  (wr_rem),
    .rd_addr_i (rd_addr),
    .rd_arr_o  (rd_arr),
    .rd_brs_o  (rd_brs),
    .rd_rem_o  (rd_rem)
  );

  lrts_pick_unit #(
    .AW (AW),
    .TW (TW)
  ) u_pick (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (pick_ctl),
    .idx_i    (cmp_idx_q),
    .active_i (act_q[cmp_idx_q]),
    .arr_i    (rd_arr),
    .brs_i    (rd_brs),
    .rem_i    (rd_rem),
    .tick_i   (tick_q),
    .found_o  (found),
    .idx_o    (best_idx),
    .arr_o    (best_arr),
    .brs_o    (best_brs),
    .rem_o    (best_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      act_q       <= '0;
      cnt_q       <= '0;
      scan_q      <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      done_q      <= 1'b0;
      comp_q      <= '0;
      turn_q      <= '0;
      out_valid_q <= 1'b0;
      idle_q      <= 1'b0;
      ran_q       <= '0;
      fin_q       <= 1'b0;
      comp_out_q  <= '0;
      turn_out_q  <= '0;
      wait_out_q  <= '0;
      all_done_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_RES)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (is_load) begin
              if (in_range) begin
                act_q[load_addr] <= (load_brs != '0);
                cnt_q  <= cnt_q - CW'(act_q[load_addr]) + CW'(load_brs != '0);
                tick_q <= '0;
              end
            end else begin
              scan_q  <= '0;
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_q < CW'(JOB_COUNT)) begin
            cmp_vld_q <= 1'b1;
            cmp_idx_q <= rd_addr;
            scan_q    <= scan_q + CW'(1);
          end else begin
            cmp_vld_q <= 1'b0;
            state_q   <= ST_UPD;
          end
        end
        ST_UPD: begin
          done_q <= found && (new_rem == '0);
          comp_q <= end_tick;
          turn_q <= (end_tick >= best_arr) ? end_tick - best_arr : '0;
          if (found && (new_rem == '0)) begin
            act_q[best_idx] <= 1'b0;
            cnt_q <= cnt_q - CW'(1);
          end
          tick_q  <= end_tick;
          state_q <= ST_RES;
        end
        ST_RES: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            idle_q      <= !found;
            ran_q       <= found ? 4'(best_idx) : 4'd0;
            fin_q       <= done_q;
            comp_out_q  <= done_q ? 16'(comp_q) : 16'd0;
            turn_out_q  <= done_q ? 16'(turn_q) : 16'd0;
            wait_out_q  <= done_q ? 16'(wait_val) : 16'd0;
            all_done_q  <= (cnt_q == '0);
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign idle_o            = idle_q;
  assign ran_job_o         = ran_q;
  assign finished_o        = fin_q;
  assign completion_time_o = comp_out_q;
  assign turnaround_time_o = turn_out_q;
  assign waiting_time_o    = wait_out_q;
  assign all_done_o        = all_done_q;

endmodule

@@ design/lrts_job_mem.sv @@
// Job table memory: arrival, burst and remaining work, with a registered read.
module lrts_job_mem #(
  parameter int AW = 4,
  parameter int TW = 16
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [TW-1:0] wr_arr_i,
  input  logic [TW-1:0] wr_brs_i,
  input  logic [TW-1:0] wr_rem_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [TW-1:0] rd_arr_o,
  output logic [TW-1:0] rd_brs_o,
  output logic [TW-1:0] rd_rem_o
);

  logic [3*TW-1:0] mem [2**AW];
  logic [3*TW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_arr_i, wr_brs_i, wr_rem_i};
    end
    rdata_q <= mem[rd_addr_i];
  end

  assign rd_arr_o = rdata_q[3*TW-1:2*TW];
  assign rd_brs_o = rdata_q[2*TW-1:TW];
  assign rd_rem_o = rdata_q[TW-1:0];

endmodule

@@ design/lrts_pick_unit.sv @@
// Running selection of the eligible job with the most remaining work.
module lrts_pick_unit import lrts_pkg::*; #(
  parameter int AW = 4,
  parameter int TW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pick_ctl_t     ctl_i,
  input  logic [AW-1:0] idx_i,
  input  logic          active_i,
  input  logic [TW-1:0] arr_i,
  input  logic [TW-1:0] brs_i,
  input  logic [TW-1:0] rem_i,
  input  logic [TW-1:0] tick_i,
  output logic          found_o,
  output logic [AW-1:0] idx_o,
  output logic [TW-1:0] arr_o,
  output logic [TW-1:0] brs_o,
  output logic [TW-1:0] rem_o
);

  logic          found_q;
  logic [AW-1:0] idx_q;
  logic [TW-1:0] arr_q, brs_q, rem_q;
  logic          take;

  assign take = ctl_i.cmp_vld && active_i && (arr_i <= tick_i) &&
                (!found_q || (rem_i > rem_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.clear) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !ctl_i.clear) begin
      idx_q <= idx_i;
      arr_q <= arr_i;
      brs_q <= brs_i;
      rem_q <= rem_i;
    end
  end

  assign found_o = found_q;
  assign idx_o   = idx_q;
  assign arr_o   = arr_q;
  assign brs_o   = brs_q;
  assign rem_o   = rem_q;

endmodule
